### rtl/rfcm_pkg.sv
// ----------------------------------------------------------------------------
// rfcm_pkg
// Constants and codes for the card reader frame matcher.
// ----------------------------------------------------------------------------
package rfcm_pkg;

   localparam int RX_BYTE_WIDTH   = 8;
   localparam int CARD_ID_WIDTH   = 32;
   localparam int MATCH_WIDTH     = 2;
   localparam int POS_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   // card_match then card_id, padded to whole bytes
   localparam int RSP_PACK_WIDTH  = MATCH_WIDTH + CARD_ID_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_PACK_WIDTH + 7) / 8) * 8;

   localparam logic [RX_BYTE_WIDTH-1:0] HDR_CMD     = 8'h04;
   localparam logic [RX_BYTE_WIDTH-1:0] HDR_LEN     = 8'h0C;
   localparam logic [RX_BYTE_WIDTH-1:0] MODE_ACTIVE = 8'h02;
   localparam logic [RX_BYTE_WIDTH-1:0] STATUS_OK   = 8'h00;

   // frame byte positions
   localparam logic [POS_WIDTH-1:0] POS_HUNT     = 4'd0;
   localparam logic [POS_WIDTH-1:0] POS_LEN      = 4'd1;
   localparam logic [POS_WIDTH-1:0] POS_MODE     = 4'd2;
   localparam logic [POS_WIDTH-1:0] POS_STATUS   = 4'd4;
   localparam logic [POS_WIDTH-1:0] POS_ID_FIRST = 4'd7;
   localparam logic [POS_WIDTH-1:0] POS_ID_LAST  = 4'd10;
   localparam logic [POS_WIDTH-1:0] POS_LAST     = 4'd11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KNOWN_CARD_ONE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KNOWN_CARD_TWO = 2'd1;

   localparam logic [CARD_ID_WIDTH-1:0] KNOWN_CARD_ONE_RESET = 32'hB385_7A5C;
   localparam logic [CARD_ID_WIDTH-1:0] KNOWN_CARD_TWO_RESET = 32'hC3CD_7228;

   typedef enum logic [MATCH_WIDTH-1:0] {
      MATCH_NONE   = 2'd0,
      MATCH_FIRST  = 2'd1,
      MATCH_SECOND = 2'd2
   } card_match_type;

endpackage

### rtl/rfid_card_frame_matcher.sv
// ----------------------------------------------------------------------------
// rfid_card_frame_matcher
// Hunts for 0x04 0x0C frames in a byte stream, checks mode and status,
// extracts the card id and compares it with two known cards.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------
//  req_     | in  | one received reader byte
//  rsp_     | out | card match code and 32-bit card id, one per good frame
//  csr_     | in  | index 0 known card one, index 1 known card two
//
//  Each byte passes through the input register, then frame decode into the
//  result register. One byte per cycle while no held result stalls decode.
//  A held result stalls the decode stage only; the input register still
//  takes a byte while it is empty. Reset (synchronous) starts hunting with
//  both known cards at their default ids.
// ----------------------------------------------------------------------------
module rfid_card_frame_matcher (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rfcm_pkg::RX_BYTE_WIDTH-1:0]   req_tdata,   // [7:0] rx_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rfcm_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,   // [1:0] card_match,
                                                             // [33:2] card_id
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rfcm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import rfcm_pkg::*;

   logic                      in_valid_ff;
   logic [RX_BYTE_WIDTH-1:0]  in_byte_ff;
   logic [POS_WIDTH-1:0]      frame_position_ff, frame_position_in;
   logic                      mode_good_ff, mode_good_in;
   logic                      status_good_ff, status_good_in;
   logic [CARD_ID_WIDTH-1:0]  id_shift_ff, id_shift_in;
   logic [CARD_ID_WIDTH-1:0]  known_card_one_ff, known_card_two_ff;
   logic                      rsp_valid_ff;
   card_match_type            rsp_match_ff, match_in;
   logic [CARD_ID_WIDTH-1:0]  rsp_id_ff;
   logic                      out_free, advance, emit;
   logic [POS_WIDTH-1:0]      pos;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // frame decode
   always_comb begin
      pos               = (frame_position_ff > POS_LAST) ? POS_HUNT : frame_position_ff;
      frame_position_in = POS_HUNT;
      mode_good_in      = mode_good_ff;
      status_good_in    = status_good_ff;
      id_shift_in       = id_shift_ff;
      emit              = 1'b0;
      case (pos)
         POS_HUNT: begin
            frame_position_in = (in_byte_ff == HDR_CMD) ? POS_LEN : POS_HUNT;
         end
         POS_LEN: begin
            // a bad length byte may itself start a new header
            if (in_byte_ff == HDR_LEN)
               frame_position_in = POS_MODE;
            else
               frame_position_in = (in_byte_ff == HDR_CMD) ? POS_LEN : POS_HUNT;
         end
         default: begin
            if (pos == POS_MODE)
               mode_good_in = (in_byte_ff == MODE_ACTIVE);
            if (pos == POS_STATUS)
               status_good_in = (in_byte_ff == STATUS_OK);
            if (pos >= POS_ID_FIRST && pos <= POS_ID_LAST)
               id_shift_in = {id_shift_ff[CARD_ID_WIDTH-RX_BYTE_WIDTH-1:0], in_byte_ff};
            if (pos == POS_LAST) begin
               frame_position_in = POS_HUNT;
               emit              = mode_good_ff && status_good_ff;
            end else begin
               frame_position_in = pos + 4'd1;
            end
         end
      endcase
   end

   always_comb begin
      if (id_shift_ff == known_card_one_ff)
         match_in = MATCH_FIRST;
      else if (id_shift_ff == known_card_two_ff)
         match_in = MATCH_SECOND;
      else
         match_in = MATCH_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         frame_position_ff <= POS_HUNT;
         mode_good_ff      <= 1'b0;
         status_good_ff    <= 1'b0;
         id_shift_ff       <= '0;
         known_card_one_ff <= KNOWN_CARD_ONE_RESET;
         known_card_two_ff <= KNOWN_CARD_TWO_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_tdata;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            frame_position_ff <= frame_position_in;
            mode_good_ff      <= mode_good_in;
            status_good_ff    <= status_good_in;
            id_shift_ff       <= id_shift_in;
            rsp_valid_ff      <= emit;
            if (emit) begin
               rsp_match_ff <= match_in;
               rsp_id_ff    <= id_shift_ff;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KNOWN_CARD_ONE: known_card_one_ff <= csr_data;
               CSR_KNOWN_CARD_TWO: known_card_two_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-RSP_PACK_WIDTH){1'b0}}, rsp_id_ff, rsp_match_ff};

   // assertions
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      frame_position_ff <= POS_LAST)
      else $error("frame position out of range");

   a_emit_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (frame_position_ff == POS_HUNT))
      else $error("result loaded without returning to hunt");

   a_first_match_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_match_ff == MATCH_FIRST) |-> (rsp_id_ff == known_card_one_ff))
      else $error("first card match with a different id");

   a_second_match_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_match_ff == MATCH_SECOND) |->
         (rsp_id_ff == known_card_two_ff && rsp_id_ff != known_card_one_ff))
      else $error("second card match inconsistent with known ids");

endmodule
